@@ src/cbc_pkg.sv @@
// shared types, codes and helper functions for the cartridge bank controller
// no dependencies; imported by every module of the block
package cbc_pkg;

    // storage sizes (internal ram is a power of two in bytes)
    localparam int RAM_BYTES        = 131072;
    localparam int RAM_AW           = $clog2(RAM_BYTES);
    localparam int TICKS_PER_SECOND = 4194304;
    localparam int SUB_W            = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;

    // channel widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 4;

    // controller kinds
    localparam logic [1:0] CK_NONE  = 2'd0;
    localparam logic [1:0] CK_MODE1 = 2'd1;
    localparam logic [1:0] CK_MODE3 = 2'd2;
    localparam logic [1:0] CK_MODE5 = 2'd3;

    // request commands
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ROM  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RUMBLE = 3'd4;

    // ram size codes
    localparam logic [2:0] RSZ_2K   = 3'd1;
    localparam logic [2:0] RSZ_8K   = 3'd2;
    localparam logic [2:0] RSZ_32K  = 3'd3;
    localparam logic [2:0] RSZ_128K = 3'd4;
    localparam logic [2:0] RSZ_64K  = 3'd5;

    // read data source of a result
    localparam logic [1:0] SRC_FF  = 2'd0;
    localparam logic [1:0] SRC_RAM = 2'd1;
    localparam logic [1:0] SRC_CLK = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic clear;   // write one cleared ram byte
        logic accept;  // capture the incoming request
        logic exec;    // decode and apply the captured request
        logic finish;  // load the result into the output register
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;   // clearing pass at its last byte
        logic out_stall;  // output register full and not taken
    } t_dp_stat;

    // writable bits of each clock register
    function automatic logic [7:0] clock_mask(input logic [2:0] idx);
        logic [7:0] m;
        case (idx)
            3'd0:    m = 8'h3F;
            3'd1:    m = 8'h3F;
            3'd2:    m = 8'h1F;
            3'd3:    m = 8'hFF;
            3'd4:    m = 8'hC1;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

    // address mask of the ram for a size code, capped at the built ram
    function automatic logic [RAM_AW-1:0] ram_mask(input logic [2:0] code);
        logic [17:0] s;
        case (code)
            RSZ_2K:   s = 18'h00800;
            RSZ_8K:   s = 18'h02000;
            RSZ_32K:  s = 18'h08000;
            RSZ_128K: s = 18'h20000;
            RSZ_64K:  s = 18'h10000;
            default:  s = 18'h00001;
        endcase
        if (s > 18'(RAM_BYTES)) s = 18'(RAM_BYTES);
        return RAM_AW'(s - 18'd1);
    endfunction

    // size code that maps any ram at all
    function automatic logic ram_present(input logic [2:0] code);
        return (code >= RSZ_2K) && (code <= RSZ_64K);
    endfunction

endpackage

@@ src/cbc_ctrl.sv @@
// controller state machine: ram clearing pass, request accept, execute, result load
// depends on cbc_pkg for the command and status structs
module cbc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  cbc_pkg::t_dp_stat i_stat,
    output logic              o_req_ready,
    output cbc_pkg::t_dp_cmd  o_cmd
);
    import cbc_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (i_req_valid) n_state = ST_EXEC;
            ST_EXEC:  n_state = ST_DONE;
            ST_DONE:  if (!i_stat.out_stall) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    assign o_req_ready  = (r_state == ST_IDLE);
    assign o_cmd.clear  = (r_state == ST_CLEAR);
    assign o_cmd.accept = (r_state == ST_IDLE) && i_req_valid;
    assign o_cmd.exec   = (r_state == ST_EXEC);
    assign o_cmd.finish = (r_state == ST_DONE) && !i_stat.out_stall;

endmodule

@@ src/cbc_datapath.sv @@
// datapath: config and mapper registers, clock counters, internal ram, output register
// depends on cbc_pkg; driven by cbc_ctrl commands
module cbc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cbc_pkg::t_dp_cmd              i_cmd,
    output cbc_pkg::t_dp_stat             o_stat,
    input  logic [1:0]                    i_req_user,
    input  logic [cbc_pkg::S_DATA_W-1:0]  i_req_data,
    input  logic                          i_cfg_we,
    input  logic [cbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cbc_pkg::CFG_DAT_W-1:0] i_cfg_dat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_out_user,
    output logic [cbc_pkg::M_DATA_W-1:0]  o_out_data
);
    import cbc_pkg::*;

    // configuration
    logic [1:0] r_ctl_kind;
    logic [3:0] r_rom_code;
    logic [2:0] r_ram_code;
    logic       r_has_clk;
    logic       r_has_rmb;

    // captured request
    logic [1:0]  r_cmd;
    logic [15:0] r_addr;
    logic [7:0]  r_val;

    // mapper state
    logic [7:0] r_rom_low;
    logic [1:0] r_bank_hi;
    logic [7:0] r_ram_sel;
    logic       r_bank_mode;
    logic       r_ram_en;
    logic [7:0] r_last_latch;
    logic       r_rumble;
    logic [7:0] r_clk [5];
    logic [7:0] r_clk_lat [5];
    logic [SUB_W-1:0] r_sub;

    // ram and clearing pass
    logic [7:0]        r_mem [RAM_BYTES];
    logic [RAM_AW-1:0] r_clr_idx;
    logic [7:0]        r_ram_q;
    logic [7:0]        r_clk_q;

    // result held between execute and load
    logic [1:0]  r_res_kind;
    logic [22:0] r_res_rom;
    logic [1:0]  r_res_src;

    // output register
    logic                r_out_valid;
    logic [1:0]          r_out_kind;
    logic [M_DATA_W-1:0] r_out_data;

    // decode
    logic              is_rom_area;
    logic              is_ram_area;
    logic              clk_sel;
    logic              rtc_path;
    logic              ram_on;
    logic [2:0]        clk_idx;
    logic [7:0]        ram_bank;
    logic [20:0]       ram_lin;
    logic [RAM_AW-1:0] ram_off;
    logic [3:0]        rom_code_c;
    logic [8:0]        rom_mask;
    logic [9:0]        rom_bank;
    logic [22:0]       rom_addr;
    logic              do_read;
    logic              do_write;
    logic              do_tick;
    logic              wr_ram;
    logic              wr_clk;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_wa;
    logic [7:0]        ram_wd;
    logic [SUB_W:0]    sub_inc;
    logic              sec_wrap;
    logic [7:0]        adv [5];
    logic [9:0]        day;
    logic [7:0]        day_hi;
    logic [7:0]        rd_byte;

    assign is_rom_area = !r_addr[15];
    assign is_ram_area = (r_addr[15:13] == 3'b101);
    assign clk_sel     = r_has_clk && (r_ram_sel >= 8'd8) && (r_ram_sel <= 8'd12);
    assign rtc_path    = (r_ctl_kind == CK_MODE3) && (r_ram_sel >= 8'd4);
    assign ram_on      = ram_present(r_ram_code);
    assign clk_idx     = r_ram_sel[2:0];

    assign do_read  = i_cmd.exec && (r_cmd == CMD_READ);
    assign do_write = i_cmd.exec && (r_cmd == CMD_WRITE);
    assign do_tick  = i_cmd.exec && (r_cmd == CMD_TICK) && r_has_clk && !r_clk[4][6];

    // ram bank and wrapped ram offset
    always_comb begin
        ram_bank = 8'd0;
        if (r_ctl_kind == CK_MODE1 && r_bank_mode) begin
            ram_bank = {6'd0, r_bank_hi};
        end else if (r_ctl_kind == CK_MODE3 || r_ctl_kind == CK_MODE5) begin
            ram_bank = r_ram_sel;
        end
    end
    assign ram_lin = {ram_bank, r_addr[12:0]};
    assign ram_off = ram_lin[RAM_AW-1:0] & ram_mask(r_ram_code);

    // rom bank selection
    always_comb begin
        rom_code_c = (r_rom_code > 4'd8) ? 4'd8 : r_rom_code;
        rom_mask   = 9'((10'd2 << rom_code_c) - 10'd1);
        rom_bank   = {9'd0, r_addr[14]};
        unique case (r_ctl_kind)
            CK_MODE1: begin
                if (!r_addr[14]) begin
                    rom_bank = r_bank_mode ? {3'd0, r_bank_hi, 5'd0} : 10'd0;
                end else begin
                    rom_bank = {3'd0, r_bank_hi, 5'd0} | {2'd0, r_rom_low};
                end
            end
            CK_MODE3: if (r_addr[14]) rom_bank = {2'd0, r_rom_low};
            CK_MODE5: if (r_addr[14]) rom_bank = {r_bank_hi, r_rom_low};
            default:  rom_bank = {9'd0, r_addr[14]};
        endcase
        rom_addr = {rom_bank[8:0] & rom_mask, r_addr[13:0]};
    end

    // ram and clock register writes from the bus
    assign wr_ram = do_write && is_ram_area && r_ram_en && !rtc_path && ram_on;
    assign wr_clk = do_write && is_ram_area && r_ram_en && rtc_path && clk_sel;

    // one second of clock advance, carrying through the counters
    always_comb begin
        for (int k = 0; k < 5; k++) adv[k] = r_clk[k];
        day    = {1'b0, r_clk[4][0], r_clk[3]} + 10'd1;
        day_hi = r_clk[4];
        if (day > 10'd511) day_hi = day_hi | 8'h80;
        adv[0] = r_clk[0] + 8'd1;
        if (adv[0] >= 8'd60) begin
            adv[0] = 8'd0;
            adv[1] = r_clk[1] + 8'd1;
            if (adv[1] >= 8'd60) begin
                adv[1] = 8'd0;
                adv[2] = r_clk[2] + 8'd1;
                if (adv[2] >= 8'd24) begin
                    adv[2] = 8'd0;
                    adv[3] = day[7:0];
                    adv[4] = (day_hi & 8'hC0) | {7'd0, day[8]};
                end
            end
        end
    end

    assign sub_inc  = {1'b0, r_sub} + (SUB_W+1)'(1);
    assign sec_wrap = (sub_inc >= (SUB_W+1)'(TICKS_PER_SECOND));

    // mapper, clock and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_kind   <= CK_NONE;
            r_rom_code   <= 4'd0;
            r_ram_code   <= 3'd0;
            r_has_clk    <= 1'b0;
            r_has_rmb    <= 1'b0;
            r_rom_low    <= 8'd1;
            r_bank_hi    <= 2'd0;
            r_ram_sel    <= 8'd0;
            r_bank_mode  <= 1'b0;
            r_ram_en     <= 1'b1;
            r_last_latch <= 8'hFF;
            r_rumble     <= 1'b0;
            r_sub        <= '0;
            for (int k = 0; k < 5; k++) begin
                r_clk[k]     <= 8'd0;
                r_clk_lat[k] <= 8'd0;
            end
        end else begin
            // mapper register writes
            if (do_write && is_rom_area && r_ctl_kind != CK_NONE) begin
                unique case (r_addr[14:13])
                    2'd0: r_ram_en <= (r_val[3:0] == 4'hA);
                    2'd1: begin
                        if (r_ctl_kind == CK_MODE5) begin
                            if (!r_addr[12]) r_rom_low <= r_val;
                            else r_bank_hi <= {1'b0, r_val[0]};
                        end else if (r_ctl_kind == CK_MODE1) begin
                            r_rom_low <= (r_val[4:0] == 5'd0) ? 8'd1 : {3'd0, r_val[4:0]};
                        end else begin
                            r_rom_low <= (r_val[6:0] == 7'd0) ? 8'd1 : {1'b0, r_val[6:0]};
                        end
                    end
                    2'd2: begin
                        if (r_ctl_kind == CK_MODE1) begin
                            r_bank_hi <= r_val[1:0];
                        end else if (r_ctl_kind == CK_MODE5) begin
                            r_ram_sel <= r_has_rmb ? {5'd0, r_val[2:0]} : {4'd0, r_val[3:0]};
                            r_rumble  <= r_has_rmb && r_val[3];
                        end else begin
                            r_ram_sel <= r_val;
                        end
                    end
                    2'd3: begin
                        if (r_ctl_kind == CK_MODE1) begin
                            r_bank_mode <= r_val[0];
                        end else if (r_ctl_kind == CK_MODE3) begin
                            // latch on a zero then one sequence
                            if (r_last_latch == 8'd0 && r_val == 8'd1 && r_has_clk) begin
                                for (int k = 0; k < 5; k++) r_clk_lat[k] <= r_clk[k];
                            end
                            r_last_latch <= r_val;
                        end
                    end
                    default: r_ram_en <= r_ram_en;
                endcase
            end
            // clock register write through the ram window
            if (wr_clk) begin
                r_clk[clk_idx] <= r_val & clock_mask(clk_idx);
                if (clk_idx == 3'd0) r_sub <= '0;
            end
            // clock tick
            if (do_tick) begin
                if (sec_wrap) begin
                    r_sub <= '0;
                    for (int k = 0; k < 5; k++) r_clk[k] <= adv[k];
                end else begin
                    r_sub <= sub_inc[SUB_W-1:0];
                end
            end
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_KIND: begin
                        r_ctl_kind <= i_cfg_dat[1:0];
                        r_ram_en   <= (i_cfg_dat[1:0] == CK_NONE);
                    end
                    CFG_ROM:    r_rom_code <= i_cfg_dat;
                    CFG_RAM:    r_ram_code <= i_cfg_dat[2:0];
                    CFG_CLOCK:  r_has_clk  <= i_cfg_dat[0];
                    CFG_RUMBLE: r_has_rmb  <= i_cfg_dat[0];
                    default:    r_has_rmb  <= r_has_rmb;
                endcase
            end
        end
    end

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end
    assign o_stat.clr_last = (r_clr_idx == RAM_AW'(RAM_BYTES - 1));

    // internal ram, one write and one registered read port
    assign ram_we = i_cmd.clear || wr_ram;
    assign ram_wa = i_cmd.clear ? r_clr_idx : ram_off;
    assign ram_wd = i_cmd.clear ? 8'hFF : r_val;

    always_ff @(posedge i_clk) begin
        if (ram_we) r_mem[ram_wa] <= ram_wd;
        if (do_read) r_ram_q <= r_mem[ram_off];
    end

    // request capture and result decode
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= i_req_user;
            r_addr <= i_req_data[15:0];
            r_val  <= i_req_data[23:16];
        end
        if (i_cmd.exec) begin
            r_res_kind <= KIND_NONE;
            r_res_rom  <= 23'd0;
            r_res_src  <= SRC_FF;
            if (r_cmd == CMD_READ) begin
                if (is_rom_area) begin
                    r_res_kind <= KIND_ROM;
                    r_res_rom  <= rom_addr;
                end else begin
                    r_res_kind <= KIND_DATA;
                    if (is_ram_area && r_ram_en) begin
                        if (rtc_path) begin
                            if (clk_sel) r_res_src <= SRC_CLK;
                        end else if (ram_on) begin
                            r_res_src <= SRC_RAM;
                        end
                    end
                end
            end
            if (clk_sel) r_clk_q <= r_clk_lat[clk_idx];
        end
    end

    // read byte of the result
    always_comb begin
        case (r_res_src)
            SRC_RAM: rd_byte = r_ram_q;
            SRC_CLK: rd_byte = r_clk_q;
            default: rd_byte = 8'hFF;
        endcase
        if (r_res_kind != KIND_DATA) rd_byte = 8'd0;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_kind <= r_res_kind;
            r_out_data <= {r_rumble, rd_byte, r_res_rom};
        end
    end

    assign o_stat.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_user       = r_out_kind;
    assign o_out_data       = r_out_data;

endmodule

@@ src/cartridge_bank_controller_unit.sv @@
// top level of the cartridge bank controller: controller plus datapath
// depends on cbc_pkg, cbc_ctrl and cbc_datapath
//
//   channel   direction   handshake            payload
//   s_*       in          s_tvalid/s_tready    tuser cmd, tdata address + value
//   m_*       out         m_tvalid/m_tready    tuser kind, tdata rom_addr + data + rumble
//   i_cfg_*   in          i_cfg_valid/ready    register index and value
//
// every request passes through accept, execute (ram port access) and result load
// the result waits in an output register, so the next request is taken meanwhile
// after reset a clearing pass fills the ram with 0xFF, one byte a cycle, over all
// 131072 bytes; requests wait, configuration writes are taken
// a stalled m side holds its result and blocks the result load, and so the taking of a new request
module cartridge_bank_controller_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cbc_pkg::S_DATA_W-1:0]  s_tdata,  // address[15:0], value[23:16]
    input  logic [1:0]                    s_tuser,  // cmd[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cbc_pkg::M_DATA_W-1:0]  m_tdata,  // rom_addr[22:0], read_data[30:23], rumble[31]
    output logic [1:0]                    m_tuser,  // kind[1:0]
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import cbc_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    cbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .i_stat      (dp_stat),
        .o_req_ready (s_tready),
        .o_cmd       (dp_cmd)
    );

    cbc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_req_user  (s_tuser),
        .i_req_data  (s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_idx   (i_cfg_index),
        .i_cfg_dat   (i_cfg_data),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_out_user  (m_tuser),
        .o_out_data  (m_tdata)
    );

endmodule

@@ src/cbc_checker.sv @@
// port-level checks of the cartridge bank controller, bound to the top level
// depends on cbc_pkg for the result kind codes
module cbc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cbc_pkg::M_DATA_W-1:0]  m_tdata,
    input logic [1:0]                    m_tuser
);
    import cbc_pkg::*;

    // one request in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // rom address only on rom fetches
    a_rom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != KIND_ROM) |-> (m_tdata[22:0] == 23'd0))
        else $error("rom address set on a non rom result");

    // read data only on data results
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (m_tuser != KIND_DATA) |-> (m_tdata[30:23] == 8'd0))
        else $error("read data set on a non data result");

endmodule

bind cartridge_bank_controller_unit cbc_checker u_cbc_checker (.*);

@@ tb/sv/testbench.sv @@
// self-checking bench for cartridge_bank_controller_unit: random and directed bus requests
// under several mapper settings, checked against an in-bench model of the mapper
// depends on cbc_pkg and the cartridge_bank_controller_unit sources
module testbench;
    import cbc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_GAP       = 15;
    // the ram clearing pass after reset is the longest quiet stretch of a good run
    localparam int IDLE_LIMIT    = 4 * RAM_BYTES;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 165;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam logic [2:0] RAM_CODE_NONE   = 3'd0;
    localparam logic [2:0] RAM_CODE_SPARE6 = 3'd6;
    localparam logic [2:0] RAM_CODE_SPARE7 = 3'd7;
    localparam logic [3:0] ROM_CODE_MIN    = 4'd0;
    localparam logic [3:0] ROM_CODE_CAP    = 4'd8;
    localparam logic [3:0] ROM_CODE_TOP    = 4'd15;

    typedef struct packed {
        logic [1:0]  kind;
        logic [22:0] rom_addr;
        logic [7:0]  read_data;
        logic        rumble;
    } t_bus_reply;

    typedef struct {
        logic [1:0] kind;
        logic [3:0] rom_code;
        logic [2:0] ram_code;
        logic       rtc;
        logic       motor;
    } t_mapper_setup;

    // mapper model plus the replies it owes, in request order
    class mapper_scoreboard;
        bit [1:0]    ctl_kind;
        bit [3:0]    rom_code;
        bit [2:0]    ram_code;
        bit          rtc_fitted;
        bit          motor_fitted;
        bit [7:0]    rom_low;
        bit [1:0]    bank_hi;
        bit [7:0]    ram_sel;
        bit          bank_mode;
        bit          ram_on;
        bit [7:0]    latch_prev;
        bit [7:0]    rtc_live [5];
        bit [7:0]    rtc_held [5];
        int unsigned sub_ticks;
        bit          motor_on;
        bit [7:0]    ram_mem [RAM_BYTES];
        t_bus_reply  due_replies [$];
        int unsigned mismatches, replies_seen, reads, writes, ticks, unused;

        function new();
            ctl_kind   = CK_NONE;
            rom_low    = 8'd1;
            ram_on     = 1'b1;
            latch_prev = 8'hFF;
            foreach (ram_mem[i]) ram_mem[i] = 8'hFF;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_KIND: begin
                    ctl_kind = data[1:0];
                    ram_on   = (data[1:0] == CK_NONE);
                end
                CFG_ROM:    rom_code     = data;
                CFG_RAM:    ram_code     = data[2:0];
                CFG_CLOCK:  rtc_fitted   = data[0];
                CFG_RUMBLE: motor_fitted = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned ram_span();
            int unsigned s;
            case (ram_code)
                RSZ_2K:   s = 'h800;
                RSZ_8K:   s = 'h2000;
                RSZ_32K:  s = 'h8000;
                RSZ_128K: s = 'h20000;
                RSZ_64K:  s = 'h10000;
                default:  s = 0;
            endcase
            if (s > RAM_BYTES) s = RAM_BYTES;
            return s;
        endfunction

        function int unsigned ram_slot(bit [15:0] addr, int unsigned span);
            int unsigned bank;
            bank = 0;
            if (ctl_kind == CK_MODE1 && bank_mode)
                bank = bank_hi;
            else if (ctl_kind == CK_MODE3 || ctl_kind == CK_MODE5)
                bank = ram_sel;
            return (bank * 'h2000 + (int'(addr) - 'hA000)) % span;
        endfunction

        function bit rtc_mapped();
            return rtc_fitted && ram_sel >= 8 && ram_sel <= 12;
        endfunction

        function bit [7:0] rtc_writable(int r);
            case (r)
                0, 1:    return 8'h3F;
                2:       return 8'h1F;
                3:       return 8'hFF;
                default: return 8'hC1;
            endcase
        endfunction

        // one second of the clock; counters roll over on reaching their limit
        function void next_second();
            int unsigned day;
            rtc_live[0] = rtc_live[0] + 8'd1;
            if (rtc_live[0] < 60) return;
            rtc_live[0] = 8'd0;
            rtc_live[1] = rtc_live[1] + 8'd1;
            if (rtc_live[1] < 60) return;
            rtc_live[1] = 8'd0;
            rtc_live[2] = rtc_live[2] + 8'd1;
            if (rtc_live[2] < 24) return;
            rtc_live[2] = 8'd0;
            day = {rtc_live[4][0], rtc_live[3]};
            day = day + 1;
            // day counter overflow sets the carry flag
            if (day > 511) rtc_live[4] = rtc_live[4] | 8'h80;
            rtc_live[3] = day[7:0];
            rtc_live[4] = (rtc_live[4] & 8'hC0) | {7'd0, day[8]};
        endfunction

        function void read_bus(bit [15:0] addr, output bit [22:0] rom_addr,
                               output bit [7:0] data);
            int unsigned bank, banks, code, span;
            rom_addr = '0;
            data     = '0;
            if (addr < 'h8000) begin
                code  = (rom_code > ROM_CODE_CAP) ? ROM_CODE_CAP : rom_code;
                banks = 2 << code;
                bank  = (addr < 'h4000) ? 0 : 1;
                if (ctl_kind == CK_MODE1) begin
                    if (addr < 'h4000)
                        bank = bank_mode ? (int'(bank_hi) << 5) : 0;
                    else
                        bank = (int'(bank_hi) << 5) | int'(rom_low);
                end else if (ctl_kind == CK_MODE3 && addr >= 'h4000) begin
                    bank = rom_low;
                end else if (ctl_kind == CK_MODE5 && addr >= 'h4000) begin
                    bank = (int'(bank_hi) << 8) | int'(rom_low);
                end
                bank     = bank & (banks - 1);
                rom_addr = 23'(bank * 'h4000 + (int'(addr) & 'h3FFF));
                return;
            end
            data = 8'hFF;
            if (addr < 'hA000 || addr >= 'hC000 || !ram_on) return;
            // mode three selects above the ram banks reach the clock or nothing
            if (ctl_kind == CK_MODE3 && ram_sel >= 4) begin
                if (rtc_mapped()) data = rtc_held[int'(ram_sel) - 8];
                return;
            end
            span = ram_span();
            if (span != 0) data = ram_mem[ram_slot(addr, span)];
        endfunction

        function void write_bus(bit [15:0] addr, bit [7:0] val);
            int unsigned span;
            if (addr < 'h8000) begin
                if (ctl_kind == CK_NONE) return;
                if (addr < 'h2000) begin
                    ram_on = (val[3:0] == 4'hA);
                end else if (addr < 'h4000) begin
                    if (ctl_kind == CK_MODE5) begin
                        if (addr < 'h3000) rom_low = val;
                        else bank_hi = {1'b0, val[0]};
                    end else begin
                        rom_low = val & ((ctl_kind == CK_MODE1) ? 8'h1F : 8'h7F);
                        if (rom_low == 8'd0) rom_low = 8'd1;
                    end
                end else if (addr < 'h6000) begin
                    case (ctl_kind)
                        CK_MODE1: bank_hi = val[1:0];
                        CK_MODE5: begin
                            ram_sel  = val & (motor_fitted ? 8'h07 : 8'h0F);
                            motor_on = motor_fitted && val[3];
                        end
                        default: ram_sel = val;
                    endcase
                end else if (ctl_kind == CK_MODE1) begin
                    bank_mode = val[0];
                end else if (ctl_kind == CK_MODE3) begin
                    // latch on a zero then one sequence
                    if (latch_prev == 8'd0 && val == 8'd1 && rtc_fitted) rtc_held = rtc_live;
                    latch_prev = val;
                end
                return;
            end
            if (addr < 'hA000 || addr >= 'hC000 || !ram_on) return;
            if (ctl_kind == CK_MODE3 && ram_sel >= 4) begin
                if (rtc_mapped()) begin
                    rtc_live[int'(ram_sel) - 8] = val & rtc_writable(int'(ram_sel) - 8);
                    if (ram_sel == 8) sub_ticks = 0;
                end
                return;
            end
            span = ram_span();
            if (span != 0) ram_mem[ram_slot(addr, span)] = val;
        endfunction

        function void tick_clock();
            if (!rtc_fitted || rtc_live[4][6]) return;
            sub_ticks++;
            if (sub_ticks >= TICKS_PER_SECOND) begin
                sub_ticks = 0;
                next_second();
            end
        endfunction

        // apply one accepted request and queue the reply it owes
        function void note_request(bit [1:0] cmd, bit [15:0] addr, bit [7:0] val);
            t_bus_reply r;
            bit [22:0]  ra;
            bit [7:0]   rd;
            r      = '0;
            r.kind = KIND_NONE;
            case (cmd)
                CMD_READ: begin
                    read_bus(addr, ra, rd);
                    r.kind      = (addr < 'h8000) ? KIND_ROM : KIND_DATA;
                    r.rom_addr  = ra;
                    r.read_data = rd;
                    reads++;
                end
                CMD_WRITE: begin
                    write_bus(addr, val);
                    writes++;
                end
                CMD_TICK: begin
                    tick_clock();
                    ticks++;
                end
                default: unused++;
            endcase
            r.rumble = motor_on;
            due_replies.push_back(r);
        endfunction

        function void check_reply(logic [1:0] kind, logic [M_DATA_W-1:0] tdata);
            t_bus_reply  want;
            logic [22:0] got_addr;
            logic [7:0]  got_data;
            logic        got_rumble;
            got_addr   = tdata[22:0];
            got_data   = tdata[30:23];
            got_rumble = tdata[31];
            replies_seen++;
            if (due_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("reply %0d arrived with no request outstanding: kind %0d data %h",
                             replies_seen, kind, tdata);
                return;
            end
            want = due_replies.pop_front();
            if (kind !== want.kind || got_addr !== want.rom_addr ||
                got_data !== want.read_data || got_rumble !== want.rumble) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"reply %0d mismatch (expected/actual): kind %0d/%0d ",
                              "rom_addr %h/%h read_data %h/%h rumble %0d/%0d"},
                             replies_seen, want.kind, kind, want.rom_addr, got_addr,
                             want.read_data, got_data, want.rumble, got_rumble);
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata     = '0;
    logic [1:0]           s_tuser     = '0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [1:0]           m_tuser;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    mapper_scoreboard board;
    bit               src_steady, sink_steady;   // stretches with no idling
    int unsigned      quiet_cycles, cfg_writes;

    cartridge_bank_controller_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // one bus request, after a random gap; valid stays high when the next follows at once
    task automatic send_request(logic [1:0] cmd, logic [15:0] addr, logic [7:0] val);
        int gap;
        if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {val, addr};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        board.note_request(cmd, addr, val);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        board.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic load_setup(t_mapper_setup st);
        put_reg(CFG_KIND,   CFG_DAT_W'(st.kind));
        put_reg(CFG_ROM,    st.rom_code);
        put_reg(CFG_RAM,    CFG_DAT_W'(st.ram_code));
        put_reg(CFG_CLOCK,  CFG_DAT_W'(st.rtc));
        put_reg(CFG_RUMBLE, CFG_DAT_W'(st.motor));
        i_cfg_valid <= 1'b0;
    endtask

    // stop sending and let every owed reply come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.due_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed mapper traffic with random content, some noise
    task automatic random_request();
        int         r;
        logic [1:0] cmd;
        logic [15:0] addr;
        logic [7:0] val;
        r    = $urandom_range(0, 99);
        cmd  = CMD_READ;
        addr = 16'($urandom_range(0, 'hFFFF));
        val  = 8'($urandom_range(0, 255));
        if (r < 25) begin
            addr = 16'($urandom_range(0, 'h7FFF));
        end else if (r < 40) begin
            addr = 16'($urandom_range('hA000, 'hBFFF));
        end else if (r < 45) begin
            // read anywhere
        end else if (r < 55) begin
            cmd  = CMD_WRITE;
            addr = 16'($urandom_range(0, 'h1FFF));
            if ($urandom_range(0, 3) != 0) val[3:0] = 4'hA;
        end else if (r < 63) begin
            cmd  = CMD_WRITE;
            addr = 16'($urandom_range('h2000, 'h3FFF));
        end else if (r < 71) begin
            cmd  = CMD_WRITE;
            addr = 16'($urandom_range('h4000, 'h5FFF));
            if ($urandom_range(0, 2) != 0) val = 8'($urandom_range(0, 15));
        end else if (r < 77) begin
            cmd  = CMD_WRITE;
            addr = 16'($urandom_range('h6000, 'h7FFF));
            if ($urandom_range(0, 3) != 0) val = 8'($urandom_range(0, 1));
        end else if (r < 91) begin
            cmd  = CMD_WRITE;
            addr = 16'($urandom_range('hA000, 'hBFFF));
        end else if (r < 97) begin
            cmd = CMD_TICK;
        end else begin
            cmd = 2'($urandom_range(0, 3));
        end
        send_request(cmd, addr, val);
    endtask

    // edges of the fields and the mapper corner cases, under mode three with a clock
    task automatic directed_checks();
        send_request(CMD_READ,  16'h0000, 8'h00);
        send_request(CMD_READ,  16'h7FFF, 8'hFF);
        send_request(CMD_WRITE, 16'h1FFF, 8'hFA);   // enable ram, upper nibble ignored
        send_request(CMD_WRITE, 16'h2000, 8'h00);   // bank zero maps to one
        send_request(CMD_READ,  16'h4000, 8'h00);
        send_request(CMD_WRITE, 16'h3FFF, 8'hFF);   // bank number masked
        send_request(CMD_READ,  16'h7FFF, 8'h00);
        send_request(CMD_WRITE, 16'h4000, 8'h08);   // seconds register
        send_request(CMD_WRITE, 16'hA000, 8'hFF);   // masked to writable bits
        send_request(CMD_WRITE, 16'h6000, 8'h00);
        send_request(CMD_WRITE, 16'h7FFF, 8'h01);   // latch the clock
        send_request(CMD_READ,  16'hA000, 8'h00);
        send_request(CMD_WRITE, 16'h5FFF, 8'h0C);   // day high register
        send_request(CMD_WRITE, 16'hBFFF, 8'hFF);   // sets halt and carry
        send_request(CMD_TICK,  16'h0000, 8'h00);
        send_request(CMD_READ,  16'hBFFF, 8'h00);   // still the latched copy
        send_request(CMD_WRITE, 16'h4000, 8'h05);   // unmapped select
        send_request(CMD_READ,  16'hA000, 8'h00);
        send_request(CMD_WRITE, 16'h4000, 8'h03);
        send_request(CMD_WRITE, 16'hB123, 8'h5A);
        send_request(CMD_READ,  16'hB123, 8'h00);
        send_request(CMD_READ,  16'h8000, 8'h00);   // outside ram window
        send_request(CMD_READ,  16'hFFFF, 8'h00);
        send_request(CMD_WRITE, 16'h0000, 8'h00);   // disable ram
        send_request(CMD_READ,  16'hB123, 8'h00);
        send_request(CMD_UNUSED, 16'hFFFF, 8'hFF);
    endtask

    // reply side with its own random stalls
    initial begin : reply_sink
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
            stall = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
            board.check_reply(m_tuser, m_tdata);
        end
    end

    // count cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : stimulus
        t_mapper_setup plan [PHASES];
        board = new();
        // fixed settings cover the extremes, the rest are drawn at random
        plan[0] = '{CK_MODE3, ROM_CODE_CAP, RSZ_128K, 1'b1, 1'b0};
        plan[1] = '{CK_NONE,  ROM_CODE_MIN, RAM_CODE_NONE, 1'b0, 1'b0};
        plan[2] = '{CK_MODE1, ROM_CODE_TOP, RSZ_32K, 1'b0, 1'b1};
        plan[3] = '{CK_MODE5, ROM_CODE_CAP, RSZ_128K, 1'b0, 1'b1};
        plan[4] = '{CK_MODE3, 4'd3, RSZ_8K, 1'b1, 1'b1};
        plan[5] = '{CK_MODE5, ROM_CODE_TOP, RSZ_64K, 1'b1, 1'b0};
        plan[6] = '{CK_MODE1, 4'd4, RSZ_2K, 1'b1, 1'b0};
        plan[7] = '{CK_MODE3, ROM_CODE_MIN, RAM_CODE_SPARE7, 1'b0, 1'b0};
        plan[8] = '{CK_NONE,  ROM_CODE_TOP, RAM_CODE_SPARE6, 1'b1, 1'b1};
        for (int p = 9; p < PHASES; p++) begin
            plan[p].kind     = 2'($urandom_range(0, 3));
            plan[p].rom_code = 4'($urandom_range(0, 15));
            plan[p].ram_code = 3'($urandom_range(0, 7));
            plan[p].rtc      = 1'($urandom_range(0, 1));
            plan[p].motor    = 1'($urandom_range(0, 1));
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            drain();
            load_setup(plan[p]);
            if (p == 0) directed_checks();
            repeat (PHASE_ITEMS) random_request();
        end
        drain();
        $display("covered %0d reads, %0d writes, %0d ticks, %0d unused commands",
                 board.reads, board.writes, board.ticks, board.unused);
        $display("over %0d mapper settings (%0d register writes), %0d replies, %0d mismatches",
                 PHASES, cfg_writes, board.replies_seen, board.mismatches);
        if (board.mismatches == 0 && board.due_replies.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
